[sv/rdlr_pkg.sv]
// Shared types, constants and trig table for the rotated DDA line rasterizer.
// Used by the controller, the datapath and the top level.
package rdlr_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int TRIG_BITS  = 14;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 2;
    localparam int STEP_BITS  = FRAC_BITS + 2;
    localparam int CNT_BITS   = COORD_BITS + 1;
    localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);
    localparam int OUT_BITS   = 12;
    localparam int DEG_BITS   = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PIVOT_X  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIVOT_Y  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROTATION = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
        logic advance;
        logic rot_start;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic points_zero;
    } t_status;

    function automatic logic [14:0] quarter_sin(input logic [6:0] d);
        logic [14:0] t [0:90];
        t = '{
            15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
            15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
            15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
            15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
            15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
            15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
            15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
            15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
            15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
            15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
            15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
            15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
            15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
            15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
            15'd16384};
        if (d > 7'd90) begin
            return 15'd0;
        end
        return t[d];
    endfunction

    // Degree argument is already reduced below 360.
    function automatic logic signed [15:0] sin_q14(input logic [8:0] deg);
        logic [14:0] m;
        logic        neg;
        m = '0;
        neg = 1'b0;
        if (deg <= 9'd90) begin
            m = quarter_sin(deg[6:0]);
        end else if (deg <= 9'd180) begin
            m = quarter_sin(7'(9'd180 - deg));
        end else if (deg <= 9'd270) begin
            m = quarter_sin(7'(deg - 9'd180));
            neg = 1'b1;
        end else begin
            m = quarter_sin(7'(9'd360 - deg));
            neg = 1'b1;
        end
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

[sv/rotated_dda_line_raster_core.sv]
// Rotated DDA line rasterizer: a load item fixes a segment, each step item
// yields one rotated raster point. The top level holds the configuration
// registers and the output register. Uses rdlr_pkg, rdlr_ctrl and rdlr_dp.
//
// Input channel: i_valid/o_stall with i_opcode and the four endpoints.
// Output channel: o_valid/i_stall with o_point_x, o_point_y, o_last_point.
// Configuration: i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data; always ready.
// A load computes the two increments in two restoring dividers that share one
// divisor; each produces one quotient bit per cycle over 26 bits.
// A step item that has a point pending registers the offsets and trig values,
// then the four multiplier products, then sums, truncates, saturates and loads
// the output register. A step with nothing pending gives no result.
// The input stalls while an item is at work.
// When the receiver stalls, the finished point waits in the output register;
// a following point waits in the datapath until the register frees up.
// Reset clears the segment, sets the pivot to (200,200) and the angle to 0.
module rotated_dda_line_raster_core import rdlr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_opcode,
    input  logic [COORD_BITS-1:0]      i_start_x,
    input  logic [COORD_BITS-1:0]      i_start_y,
    input  logic [COORD_BITS-1:0]      i_end_x,
    input  logic [COORD_BITS-1:0]      i_end_y,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [OUT_BITS-1:0] o_point_x,
    output logic signed [OUT_BITS-1:0] o_point_y,
    output logic                       o_last_point,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic [COORD_BITS-1:0] r_pivot_x, r_pivot_y;
    logic [DEG_BITS-1:0]   r_rotation;
    logic                  r_valid;
    t_cmd                  w_cmd;
    t_status               w_status;
    logic                  w_busy;

    assign o_cfg_ready = 1'b1;
    assign o_valid = r_valid;
    assign w_busy = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_x <= COORD_BITS'(200);
            r_pivot_y <= COORD_BITS'(200);
            r_rotation <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PIVOT_X:  r_pivot_x <= i_cfg_data;
                    CFG_PIVOT_Y:  r_pivot_y <= i_cfg_data;
                    CFG_ROTATION: r_rotation <= i_cfg_data[DEG_BITS-1:0];
                    default: ;
                endcase
            end
            if (w_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    rdlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_opcode   (i_opcode),
        .i_out_busy (w_busy),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rdlr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_pivot_x      (r_pivot_x),
        .i_pivot_y      (r_pivot_y),
        .i_rotation_deg (r_rotation),
        .o_px           (o_point_x),
        .o_py           (o_point_y),
        .o_last         (o_last_point)
    );

endmodule

[sv/rdlr_ctrl.sv]
// Controller state machine of the rotated DDA line rasterizer.
// Depends on rdlr_pkg for the command and status structs.
module rdlr_ctrl import rdlr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_opcode,
    input  logic    i_out_busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_ROT  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state = S_DIV;
                    end else if (!i_status.points_zero) begin
                        o_cmd.rot_start = 1'b1;
                        n_state = S_ROT;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_ROT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/rdlr_dp.sv]
// Datapath of the rotated DDA line rasterizer: accumulators, two restoring
// dividers sharing one divisor for the increments, and the rotation multipliers. Uses rdlr_pkg.
module rdlr_dp import rdlr_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  logic [COORD_BITS-1:0]       i_start_x,
    input  logic [COORD_BITS-1:0]       i_start_y,
    input  logic [COORD_BITS-1:0]       i_end_x,
    input  logic [COORD_BITS-1:0]       i_end_y,
    input  logic [COORD_BITS-1:0]       i_pivot_x,
    input  logic [COORD_BITS-1:0]       i_pivot_y,
    input  logic [DEG_BITS-1:0]         i_rotation_deg,
    output logic signed [OUT_BITS-1:0]  o_px,
    output logic signed [OUT_BITS-1:0]  o_py,
    output logic                        o_last
);

    logic signed [ACC_BITS-1:0]  r_acc_x, r_acc_y;
    logic signed [STEP_BITS-1:0] r_step_x, r_step_y;
    logic [CNT_BITS-1:0]         r_left;
    logic [COORD_BITS-1:0]       r_mag_x, r_mag_y, r_div;
    logic                        r_neg_x, r_neg_y;
    logic [QUO_BITS-1:0]         r_qx, r_qy;
    logic [COORD_BITS:0]         r_rx, r_ry;
    logic [DIV_CNT_BITS-1:0]     r_cnt;
    logic signed [COORD_BITS+2:0] r_ox, r_oy;
    logic signed [15:0]          r_sin, r_cos;
    logic signed [31:0]          r_m0, r_m1, r_m2, r_m3;

    logic signed [COORD_BITS:0]  w_dx, w_dy;
    logic [COORD_BITS-1:0]       w_ax, w_ay, w_steps;
    logic [COORD_BITS+1:0]       w_tx, w_ty;
    logic                        w_bit;
    logic [$clog2(COORD_BITS)-1:0] w_bsel;
    logic [8:0]                  w_deg, w_deg90;
    logic signed [ACC_BITS-1:0]  w_nax, w_nay;
    logic signed [COORD_BITS+2:0] w_pxi, w_pyi;
    logic signed [33:0]          w_vx, w_vy;
    logic signed [33:0]          w_tvx, w_tvy;

    function automatic logic signed [ACC_BITS-1:0] trunc_frac(
        input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-1:0] m;
        m = v[ACC_BITS-1] ? ACC_BITS'(-v) : v;
        m = m >> FRAC_BITS;
        return v[ACC_BITS-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] fin(input logic signed [33:0] v);
        logic [33:0]        m;
        logic signed [33:0] t;
        m = v[33] ? 34'(-v) : v;
        m = m >> TRIG_BITS;
        t = v[33] ? -$signed(m) : $signed(m);
        if (t < -34'sd2048) return -12'sd2048;
        if (t > 34'sd2047) return 12'sd2047;
        return t[OUT_BITS-1:0];
    endfunction

    assign w_dx = $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
    assign w_dy = $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
    assign w_ax = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
    assign w_ay = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
    assign w_steps = (w_ax > w_ay) ? w_ax : w_ay;

    assign w_bit = r_cnt < DIV_CNT_BITS'(COORD_BITS);
    assign w_bsel = ($clog2(COORD_BITS))'(COORD_BITS - 1)
                    - r_cnt[$clog2(COORD_BITS)-1:0];
    assign w_tx = {r_rx, w_bit ? r_mag_x[w_bsel] : 1'b0};
    assign w_ty = {r_ry, w_bit ? r_mag_y[w_bsel] : 1'b0};

    assign o_status.div_done = (r_cnt == DIV_CNT_BITS'(QUO_BITS - 1));
    assign o_status.points_zero = (r_left == '0);

    assign w_deg = (i_rotation_deg >= 9'd360) ? 9'(i_rotation_deg - 9'd360) : i_rotation_deg;
    assign w_deg90 = (w_deg >= 9'd270) ? 9'(w_deg - 9'd270) : 9'(w_deg + 9'd90);

    assign w_nax = trunc_frac(r_acc_x);
    assign w_nay = trunc_frac(r_acc_y);
    assign w_pxi = (COORD_BITS+3)'(w_nax) - $signed({3'b0, i_pivot_x});
    assign w_pyi = (COORD_BITS+3)'(w_nay) - $signed({3'b0, i_pivot_y});

    assign w_tvx = $signed({10'b0, i_pivot_x, 14'b0});
    assign w_tvy = $signed({10'b0, i_pivot_y, 14'b0});
    assign w_vx = w_tvx + 34'(r_m0) - 34'(r_m1);
    assign w_vy = w_tvy + 34'(r_m2) + 34'(r_m3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_step_x <= '0;
            r_step_y <= '0;
            r_left <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_acc_x <= $signed({2'b0, i_start_x, {FRAC_BITS{1'b0}}});
                r_acc_y <= $signed({2'b0, i_start_y, {FRAC_BITS{1'b0}}});
                r_left <= CNT_BITS'(w_steps);
                r_mag_x <= w_ax;
                r_mag_y <= w_ay;
                r_neg_x <= w_dx[COORD_BITS];
                r_neg_y <= w_dy[COORD_BITS];
                r_div <= w_steps;
                r_rx <= '0;
                r_ry <= '0;
                r_qx <= '0;
                r_qy <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                if (w_tx >= {2'b0, r_div} && r_div != '0) begin
                    r_rx <= (COORD_BITS+1)'(w_tx - {2'b0, r_div});
                    r_qx <= {r_qx[QUO_BITS-2:0], 1'b1};
                end else begin
                    r_rx <= w_tx[COORD_BITS:0];
                    r_qx <= {r_qx[QUO_BITS-2:0], 1'b0};
                end
                if (w_ty >= {2'b0, r_div} && r_div != '0) begin
                    r_ry <= (COORD_BITS+1)'(w_ty - {2'b0, r_div});
                    r_qy <= {r_qy[QUO_BITS-2:0], 1'b1};
                end else begin
                    r_ry <= w_ty[COORD_BITS:0];
                    r_qy <= {r_qy[QUO_BITS-2:0], 1'b0};
                end
                r_cnt <= o_status.div_done ? '0 : DIV_CNT_BITS'(r_cnt + 1'b1);
                if (o_status.div_done) begin
                    r_step_x <= r_neg_x ? -$signed({1'b0, r_qx[STEP_BITS-3:0], 1'b0})
                        - $signed(STEP_BITS'(w_tx >= {2'b0, r_div} && r_div != '0))
                        : $signed({1'b0, r_qx[STEP_BITS-3:0],
                                   w_tx >= {2'b0, r_div} && r_div != '0});
                    r_step_y <= r_neg_y ? -$signed({1'b0, r_qy[STEP_BITS-3:0], 1'b0})
                        - $signed(STEP_BITS'(w_ty >= {2'b0, r_div} && r_div != '0))
                        : $signed({1'b0, r_qy[STEP_BITS-3:0],
                                   w_ty >= {2'b0, r_div} && r_div != '0});
                end
            end
            if (i_cmd.advance) begin
                r_acc_x <= r_acc_x + ACC_BITS'(r_step_x);
                r_acc_y <= r_acc_y + ACC_BITS'(r_step_y);
                r_left <= CNT_BITS'(r_left - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_start) begin
            r_ox <= w_pxi;
            r_oy <= w_pyi;
            r_sin <= sin_q14(w_deg);
            r_cos <= sin_q14(w_deg90);
        end else begin
            r_m0 <= 32'(r_ox * r_cos);
            r_m1 <= 32'(r_oy * r_sin);
            r_m2 <= 32'(r_ox * r_sin);
            r_m3 <= 32'(r_oy * r_cos);
        end
        if (i_cmd.emit) begin
            o_px <= fin(w_vx);
            o_py <= fin(w_vy);
            o_last <= (r_left == CNT_BITS'(1));
        end
    end

endmodule

[sim/rdlr_checker.sv]
// Checker for the rotated DDA line rasterizer: watches the input, output and
// register-write channels, predicts each raster point and compares it.
// Depends on rdlr_pkg for widths, opcodes and register indexes.
`timescale 1ns / 100ps

module rdlr_checker import rdlr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_stall_in,
    input  logic                       i_opcode,
    input  logic [COORD_BITS-1:0]      i_start_x,
    input  logic [COORD_BITS-1:0]      i_start_y,
    input  logic [COORD_BITS-1:0]      i_end_x,
    input  logic [COORD_BITS-1:0]      i_end_y,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [OUT_BITS-1:0] i_point_x,
    input  logic signed [OUT_BITS-1:0] i_point_y,
    input  logic                       i_last_point,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_points_seen
);

    typedef struct {
        logic signed [OUT_BITS-1:0] px;
        logic signed [OUT_BITS-1:0] py;
        logic                       last;
    } t_point;

    t_point points_due[$];
    longint piv_x, piv_y, angle;
    longint acc_x, acc_y, inc_x, inc_y, left;

    function automatic longint trunc_div(longint v, int sh);
        if (v < 0) begin
            return -((-v) >>> sh);
        end
        return v >>> sh;
    endfunction

    function automatic longint sine_q14(longint d);
        longint r;
        r = d % 360;
        if (r <= 90) begin
            return quarter_sin(7'(r));
        end else if (r <= 180) begin
            return quarter_sin(7'(180 - r));
        end else if (r <= 270) begin
            return -longint'(quarter_sin(7'(r - 180)));
        end
        return -longint'(quarter_sin(7'(360 - r)));
    endfunction

    function automatic longint clamp12(longint v);
        if (v < -2048) begin
            return -2048;
        end else if (v > 2047) begin
            return 2047;
        end
        return v;
    endfunction

    task automatic predict_item();
        longint sx, sy, dx, dy, ax, ay, n, ox, oy, s, c;
        t_point p;
        if (i_opcode == OP_LOAD) begin
            sx = i_start_x;
            sy = i_start_y;
            dx = longint'(i_end_x) - sx;
            dy = longint'(i_end_y) - sy;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            n = ax > ay ? ax : ay;
            acc_x = sx << FRAC_BITS;
            acc_y = sy << FRAC_BITS;
            left = n;
            inc_x = 0;
            inc_y = 0;
            if (n != 0) begin
                inc_x = ((ax << FRAC_BITS) / n) * (dx < 0 ? -1 : 1);
                inc_y = ((ay << FRAC_BITS) / n) * (dy < 0 ? -1 : 1);
            end
        end else if (left != 0) begin
            ox = trunc_div(acc_x, FRAC_BITS) - piv_x;
            oy = trunc_div(acc_y, FRAC_BITS) - piv_y;
            s = sine_q14(angle);
            c = sine_q14(angle + 90);
            p.px = OUT_BITS'(clamp12(trunc_div((piv_x << TRIG_BITS) + ox * c - oy * s,
                TRIG_BITS)));
            p.py = OUT_BITS'(clamp12(trunc_div((piv_y << TRIG_BITS) + ox * s + oy * c,
                TRIG_BITS)));
            p.last = (left == 1);
            points_due.push_back(p);
            acc_x += inc_x;
            acc_y += inc_y;
            left--;
        end
    endtask

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            piv_x = 200;
            piv_y = 200;
            angle = 0;
            acc_x = 0;
            acc_y = 0;
            inc_x = 0;
            inc_y = 0;
            left = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PIVOT_X: piv_x = i_cfg_data;
                    CFG_PIVOT_Y: piv_y = i_cfg_data;
                    CFG_ROTATION: angle = i_cfg_data[DEG_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_points_seen++;
                if (points_due.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d", i_point_x, i_point_y);
                    o_errors++;
                end else begin
                    e = points_due.pop_front();
                    if (e.px !== i_point_x) begin
                        $error("point_x expected %0d actual %0d", e.px, i_point_x);
                        o_errors++;
                    end
                    if (e.py !== i_point_y) begin
                        $error("point_y expected %0d actual %0d", e.py, i_point_y);
                        o_errors++;
                    end
                    if (e.last !== i_last_point) begin
                        $error("last_point expected %0d actual %0d", e.last, i_last_point);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                predict_item();
            end
        end
        o_pending = points_due.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_points_seen = 0;
    end

endmodule

[sim/testbench.sv]
// Top of the rasterizer testbench: drives segments, step requests and register
// writes with random gaps and output stalls, and gives the verdict.
// Depends on rdlr_pkg, rotated_dda_line_raster_core and rdlr_checker.
`timescale 1ns / 100ps

module testbench;
    import rdlr_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       opcode = OP_STEP;
    logic [COORD_BITS-1:0]      sx = '0, sy = '0, ex = '0, ey = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [OUT_BITS-1:0] px, py;
    logic                       last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index = CFG_PIVOT_X;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
    int                         errors, pending, points_seen;
    int                         items_sent = 0;
    bit                         stall_enable = 1'b1;

    always #5 clk = ~clk;

    rotated_dda_line_raster_core DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(opcode), .i_start_x(sx), .i_start_y(sy), .i_end_x(ex), .i_end_y(ey),
        .o_valid(out_valid), .i_stall(out_stall), .o_point_x(px), .o_point_y(py),
        .o_last_point(last), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    rdlr_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_opcode(opcode), .i_start_x(sx), .i_start_y(sy), .i_end_x(ex), .i_end_y(ey),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_point_x(px),
        .i_point_y(py), .i_last_point(last), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_points_seen(points_seen)
    );

    // Receiver inserts random stalls before each point, with stall-free stretches.
    initial begin
        int n;
        forever begin
            n = stall_enable ? $urandom_range(0, 3) : 0;
            repeat (n) begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) begin
                @(posedge clk);
            end
        end
    end

    task automatic send(input logic op, input logic [COORD_BITS-1:0] a, b, c, d);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        sx <= a;
        sy <= b;
        ex <= c;
        ey <= d;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic seg(input logic [COORD_BITS-1:0] a, b, c, d, input int steps);
        send(OP_LOAD, a, b, c, d);
        repeat (steps) send(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                            COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input int x, input int y, input int deg);
        drain();
        write_reg(CFG_PIVOT_X, CFG_DATA_BITS'(x));
        write_reg(CFG_PIVOT_Y, CFG_DATA_BITS'(y));
        write_reg(CFG_ROTATION, CFG_DATA_BITS'(deg));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase, len, x0, y0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: step with nothing pending, zero length, extremes, replaced segment.
        send(OP_STEP, 0, 0, 0, 0);
        seg(0, 0, 0, 0, 2);
        seg(0, 0, 1023, 1023, 3);
        seg(1023, 1023, 0, 0, 2);
        seg(0, 1023, 5, 1020, 6);
        seg(10, 10, 13, 11, 4);
        configure(1023, 0, 45);
        seg(0, 1023, 1023, 0, 3);
        seg(1023, 1023, 1020, 1018, 3);
        configure(0, 1023, 359);
        seg(1023, 0, 1020, 3, 4);
        drain();
        for (phase = 0; phase < 12; phase++) begin
            case (phase)
                0: configure(0, 0, 90);
                1: configure(1023, 1023, 180);
                2: configure(512, 512, 270);
                3: configure(0, 0, 0);
                default: configure($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 359));
            endcase
            stall_enable = (phase != 5);
            while (items_sent < 130 * (phase + 1)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send(1'($urandom_range(0, 1)), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom));
                end else begin
                    x0 = $urandom_range(0, 1023);
                    y0 = $urandom_range(0, 1023);
                    len = $urandom_range(0, 3) == 0 ? 40 : 6;
                    seg(COORD_BITS'(x0), COORD_BITS'(y0),
                        COORD_BITS'($urandom_range(x0 < len ? 0 : x0 - len,
                                                   x0 + len > 1023 ? 1023 : x0 + len)),
                        COORD_BITS'($urandom_range(y0 < len ? 0 : y0 - len,
                                                   y0 + len > 1023 ? 1023 : y0 + len)),
                        $urandom_range(0, 2 * len + 2));
                end
            end
        end
        stall_enable = 1'b1;
        drain();
        $display("Covered %0d input transfers and %0d checked points over fifteen settings.",
                 items_sent, points_seen);
        if (errors == 0) begin
            $display("rotated_dda_line_raster_core: match");
        end else begin
            $display("rotated_dda_line_raster_core: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("rotated_dda_line_raster_core: mismatch");
        $finish;
    end

endmodule

[rotated_dda_line_raster_core.f]
sv/rdlr_pkg.sv
sv/rdlr_ctrl.sv
sv/rdlr_dp.sv
sv/rotated_dda_line_raster_core.sv
sim/rdlr_checker.sv
sim/testbench.sv
